FILE: src/slfr_pkg.sv
`timescale 1ns / 1ps

package slfr_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int FRAME_OVERHEAD  = 8;

    localparam int CNT_W  = $clog2(MAX_FRAME_BYTES + 1);
    localparam int ADDR_W = $clog2(MAX_FRAME_BYTES);
    localparam int MEM_W  = ADDR_W + 1;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    typedef enum logic [1:0] {
        ST_INCOMPLETE = 2'd0,
        ST_COMPLETE   = 2'd1,
        ST_BAD_SYNC   = 2'd2,
        ST_OVERFLOW   = 2'd3
    } t_status;

    typedef enum logic {
        OP_RECEIVE = 1'b0,
        OP_READ    = 1'b1
    } t_op;

    typedef struct packed {
        logic              en;
        logic [MEM_W-1:0]  addr;
        logic [7:0]        data;
    } t_buf_wr;

    typedef struct packed {
        logic              en;
        logic [MEM_W-1:0]  addr;
    } t_buf_rd;

endpackage

FILE: src/slfr_frame_buf.sv
`timescale 1ns / 1ps

module slfr_frame_buf (
    input  logic                  i_clk,
    input  slfr_pkg::t_buf_wr     i_wr,
    input  slfr_pkg::t_buf_rd     i_rd,
    output logic [7:0]            o_rd_data
);

    // two banks: one collects the frame being received, the other holds the last frame
    logic [7:0] r_mem [2 * slfr_pkg::MAX_FRAME_BYTES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/sync_length_frame_receiver.sv
`timescale 1ns / 1ps

// Frame receiver for a two-byte sync (0xB5 0x62) protocol with a little-endian payload length
// in frame bytes 4 and 5; a frame is 8 + length bytes long. Every transaction, receive or read,
// is accepted and gives one result in the output register on the next cycle, so one
// transaction per clock is sustained while the output is not stalled; the rate is set by
// the single-port write and registered read of the frame buffer. The buffer has two banks
// that swap when a frame completes, so reads always see the last complete frame while the
// next one fills. No clearing pass is needed after reset: reads beyond the last frame length,
// and every read before the first frame completes, return 0.
module sync_length_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_read_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [8:0]  o_frame_length,
    output logic [7:0]  o_read_data
);

    localparam int CW = slfr_pkg::CNT_W;
    localparam int AW = slfr_pkg::ADDR_W;

    logic                 r_synced, n_synced;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_last_len, n_last_len;
    logic                 r_bank, n_bank;
    logic [7:0]           r_prev, n_prev;
    logic [7:0]           r_len_lo, n_len_lo;
    logic [7:0]           r_len_hi, n_len_hi;

    logic                 r_out_valid;
    slfr_pkg::t_status    r_status, n_status;
    logic [8:0]           r_flen, n_flen;
    logic                 r_rd_ok, n_rd_ok;

    slfr_pkg::t_buf_wr    wr;
    slfr_pkg::t_buf_rd    rd;
    logic [7:0]           rd_data;

    logic                 accept;
    logic                 is_read;
    logic [16:0]          frame_end;
    logic [CW-1:0]        count_inc;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign is_read    = (slfr_pkg::t_op'(i_operation) == slfr_pkg::OP_READ);
    assign frame_end  = {1'b0, r_len_hi, r_len_lo} + 17'(slfr_pkg::FRAME_OVERHEAD - 1);
    assign count_inc  = r_count + CW'(1);

    always_comb begin
        n_synced   = r_synced;
        n_count    = r_count;
        n_last_len = r_last_len;
        n_bank     = r_bank;
        n_prev     = r_prev;
        n_len_lo   = r_len_lo;
        n_len_hi   = r_len_hi;
        n_status   = slfr_pkg::ST_INCOMPLETE;
        n_flen     = 9'd0;
        n_rd_ok    = 1'b0;
        wr.en      = 1'b0;
        wr.addr    = {r_bank, r_count[AW-1:0]};
        wr.data    = i_rx_byte;

        rd.en      = accept && is_read;
        rd.addr    = {~r_bank, AW'(i_read_index)};

        if (is_read) begin
            n_rd_ok = (32'(i_read_index) < 32'(r_last_len)) &&
                      (32'(i_read_index) < 32'(slfr_pkg::MAX_FRAME_BYTES));
        end else if (!r_synced || r_count == '0) begin
            n_synced = 1'b0;
            n_count  = '0;
            if (i_rx_byte == slfr_pkg::SYNC_FIRST) begin
                n_synced = 1'b1;
                n_count  = CW'(1);
                n_prev   = slfr_pkg::SYNC_FIRST;
                wr.en    = 1'b1;
                wr.addr  = {r_bank, AW'(0)};
            end
        end else if (32'(r_count) >= 32'(slfr_pkg::MAX_FRAME_BYTES)) begin
            n_synced = 1'b0;
            n_count  = '0;
            n_status = slfr_pkg::ST_OVERFLOW;
        end else if (i_rx_byte == slfr_pkg::SYNC_SECOND && r_prev == slfr_pkg::SYNC_FIRST) begin
            // restart with the sync pair, index 0 of this bank already holds the first sync byte
            wr.en   = 1'b1;
            wr.addr = {r_bank, AW'(1)};
            n_count = CW'(2);
            n_prev  = slfr_pkg::SYNC_SECOND;
        end else if (r_count == CW'(1)) begin
            if (i_rx_byte != slfr_pkg::SYNC_FIRST) begin
                n_synced = 1'b0;
                n_count  = '0;
                n_status = slfr_pkg::ST_BAD_SYNC;
            end
        end else if (r_count >= CW'(7) && 17'(r_count) == frame_end) begin
            wr.en      = 1'b1;
            n_status   = slfr_pkg::ST_COMPLETE;
            n_flen     = 9'(count_inc);
            n_last_len = count_inc;
            n_bank     = ~r_bank;
            n_synced   = 1'b0;
            n_count    = '0;
        end else begin
            wr.en   = 1'b1;
            n_count = count_inc;
            n_prev  = i_rx_byte;
            if (r_count == CW'(4)) begin
                n_len_lo = i_rx_byte;
            end
            if (r_count == CW'(5)) begin
                n_len_hi = i_rx_byte;
            end
        end

        wr.en = wr.en && accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_synced    <= 1'b0;
            r_count     <= '0;
            r_last_len  <= '0;
            r_bank      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_synced   <= n_synced;
                r_count    <= n_count;
                r_last_len <= n_last_len;
                r_bank     <= n_bank;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prev   <= n_prev;
            r_len_lo <= n_len_lo;
            r_len_hi <= n_len_hi;
            r_status <= n_status;
            r_flen   <= n_flen;
            r_rd_ok  <= n_rd_ok;
        end
    end

    slfr_frame_buf u_frame_buf (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd      (rd),
        .o_rd_data (rd_data)
    );

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_frame_length = r_flen;
    assign o_read_data    = r_rd_ok ? rd_data : 8'd0;

`ifndef NO_ASSERTIONS
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted transaction gave no result");

    a_hunting_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_synced |-> r_count == '0)
        else $error("byte count nonzero while hunting");

    a_length_only_on_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_status == slfr_pkg::ST_COMPLETE) == (o_frame_length != 9'd0)))
        else $error("frame length does not match completion status");

    a_complete_swaps_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_status == slfr_pkg::ST_COMPLETE) |=> r_bank != $past(r_bank))
        else $error("bank did not swap on frame completion");
`endif

endmodule
